// ===== rtl/aesd_pkg.sv =====
// Package: AES-128 decrypt types, constants, S-box tables and GF(2^8) helpers.
package aesd_pkg;

    localparam int KEY_WORDS   = 4;
    localparam int TOTAL_WORDS = 44;
    localparam int ROUNDS      = 10;
    localparam int WORD_IDX_W  = 6;
    localparam int ROUND_IDX_W = 4;

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

    localparam logic [7:0] REDUCE_POLY = 8'h1B;

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;

    // key schedule status towards the top level
    typedef struct packed {
        logic busy;
        logic ready;
    } ks_status_t;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
            8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
            8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
            8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
            8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
            8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
            8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
            8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
            8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
            8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
            8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
            8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
            8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
            8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
            8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
            8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
            8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
            8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
            8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
            8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
            8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
            8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
            8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
            8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
            8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
            8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
            8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
            8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
            8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
            8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
            8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
            8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
            8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
            8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
            8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
            8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
            8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
            8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
            8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
            8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
            8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
            8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
            8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
            8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
            8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
            8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
            8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
            8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
            8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
            8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
            8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
            8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
            8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6A; 8'h03: r=8'hD5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'hA5; 8'h07: r=8'h38;
            8'h08: r=8'hBF; 8'h09: r=8'h40; 8'h0A: r=8'hA3; 8'h0B: r=8'h9E;
            8'h0C: r=8'h81; 8'h0D: r=8'hF3; 8'h0E: r=8'hD7; 8'h0F: r=8'hFB;
            8'h10: r=8'h7C; 8'h11: r=8'hE3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9B; 8'h15: r=8'h2F; 8'h16: r=8'hFF; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8E; 8'h1A: r=8'h43; 8'h1B: r=8'h44;
            8'h1C: r=8'hC4; 8'h1D: r=8'hDE; 8'h1E: r=8'hE9; 8'h1F: r=8'hCB;
            8'h20: r=8'h54; 8'h21: r=8'h7B; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'hA6; 8'h25: r=8'hC2; 8'h26: r=8'h23; 8'h27: r=8'h3D;
            8'h28: r=8'hEE; 8'h29: r=8'h4C; 8'h2A: r=8'h95; 8'h2B: r=8'h0B;
            8'h2C: r=8'h42; 8'h2D: r=8'hFA; 8'h2E: r=8'hC3; 8'h2F: r=8'h4E;
            8'h30: r=8'h08; 8'h31: r=8'h2E; 8'h32: r=8'hA1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hD9; 8'h36: r=8'h24; 8'h37: r=8'hB2;
            8'h38: r=8'h76; 8'h39: r=8'h5B; 8'h3A: r=8'hA2; 8'h3B: r=8'h49;
            8'h3C: r=8'h6D; 8'h3D: r=8'h8B; 8'h3E: r=8'hD1; 8'h3F: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hF8; 8'h42: r=8'hF6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hD4; 8'h49: r=8'hA4; 8'h4A: r=8'h5C; 8'h4B: r=8'hCC;
            8'h4C: r=8'h5D; 8'h4D: r=8'h65; 8'h4E: r=8'hB6; 8'h4F: r=8'h92;
            8'h50: r=8'h6C; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hFD; 8'h55: r=8'hED; 8'h56: r=8'hB9; 8'h57: r=8'hDA;
            8'h58: r=8'h5E; 8'h59: r=8'h15; 8'h5A: r=8'h46; 8'h5B: r=8'h57;
            8'h5C: r=8'hA7; 8'h5D: r=8'h8D; 8'h5E: r=8'h9D; 8'h5F: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hD8; 8'h62: r=8'hAB; 8'h63: r=8'h00;
            8'h64: r=8'h8C; 8'h65: r=8'hBC; 8'h66: r=8'hD3; 8'h67: r=8'h0A;
            8'h68: r=8'hF7; 8'h69: r=8'hE4; 8'h6A: r=8'h58; 8'h6B: r=8'h05;
            8'h6C: r=8'hB8; 8'h6D: r=8'hB3; 8'h6E: r=8'h45; 8'h6F: r=8'h06;
            8'h70: r=8'hD0; 8'h71: r=8'h2C; 8'h72: r=8'h1E; 8'h73: r=8'h8F;
            8'h74: r=8'hCA; 8'h75: r=8'h3F; 8'h76: r=8'h0F; 8'h77: r=8'h02;
            8'h78: r=8'hC1; 8'h79: r=8'hAF; 8'h7A: r=8'hBD; 8'h7B: r=8'h03;
            8'h7C: r=8'h01; 8'h7D: r=8'h13; 8'h7E: r=8'h8A; 8'h7F: r=8'h6B;
            8'h80: r=8'h3A; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4F; 8'h85: r=8'h67; 8'h86: r=8'hDC; 8'h87: r=8'hEA;
            8'h88: r=8'h97; 8'h89: r=8'hF2; 8'h8A: r=8'hCF; 8'h8B: r=8'hCE;
            8'h8C: r=8'hF0; 8'h8D: r=8'hB4; 8'h8E: r=8'hE6; 8'h8F: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hAC; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'hE7; 8'h95: r=8'hAD; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'hE2; 8'h99: r=8'hF9; 8'h9A: r=8'h37; 8'h9B: r=8'hE8;
            8'h9C: r=8'h1C; 8'h9D: r=8'h75; 8'h9E: r=8'hDF; 8'h9F: r=8'h6E;
            8'hA0: r=8'h47; 8'hA1: r=8'hF1; 8'hA2: r=8'h1A; 8'hA3: r=8'h71;
            8'hA4: r=8'h1D; 8'hA5: r=8'h29; 8'hA6: r=8'hC5; 8'hA7: r=8'h89;
            8'hA8: r=8'h6F; 8'hA9: r=8'hB7; 8'hAA: r=8'h62; 8'hAB: r=8'h0E;
            8'hAC: r=8'hAA; 8'hAD: r=8'h18; 8'hAE: r=8'hBE; 8'hAF: r=8'h1B;
            8'hB0: r=8'hFC; 8'hB1: r=8'h56; 8'hB2: r=8'h3E; 8'hB3: r=8'h4B;
            8'hB4: r=8'hC6; 8'hB5: r=8'hD2; 8'hB6: r=8'h79; 8'hB7: r=8'h20;
            8'hB8: r=8'h9A; 8'hB9: r=8'hDB; 8'hBA: r=8'hC0; 8'hBB: r=8'hFE;
            8'hBC: r=8'h78; 8'hBD: r=8'hCD; 8'hBE: r=8'h5A; 8'hBF: r=8'hF4;
            8'hC0: r=8'h1F; 8'hC1: r=8'hDD; 8'hC2: r=8'hA8; 8'hC3: r=8'h33;
            8'hC4: r=8'h88; 8'hC5: r=8'h07; 8'hC6: r=8'hC7; 8'hC7: r=8'h31;
            8'hC8: r=8'hB1; 8'hC9: r=8'h12; 8'hCA: r=8'h10; 8'hCB: r=8'h59;
            8'hCC: r=8'h27; 8'hCD: r=8'h80; 8'hCE: r=8'hEC; 8'hCF: r=8'h5F;
            8'hD0: r=8'h60; 8'hD1: r=8'h51; 8'hD2: r=8'h7F; 8'hD3: r=8'hA9;
            8'hD4: r=8'h19; 8'hD5: r=8'hB5; 8'hD6: r=8'h4A; 8'hD7: r=8'h0D;
            8'hD8: r=8'h2D; 8'hD9: r=8'hE5; 8'hDA: r=8'h7A; 8'hDB: r=8'h9F;
            8'hDC: r=8'h93; 8'hDD: r=8'hC9; 8'hDE: r=8'h9C; 8'hDF: r=8'hEF;
            8'hE0: r=8'hA0; 8'hE1: r=8'hE0; 8'hE2: r=8'h3B; 8'hE3: r=8'h4D;
            8'hE4: r=8'hAE; 8'hE5: r=8'h2A; 8'hE6: r=8'hF5; 8'hE7: r=8'hB0;
            8'hE8: r=8'hC8; 8'hE9: r=8'hEB; 8'hEA: r=8'hBB; 8'hEB: r=8'h3C;
            8'hEC: r=8'h83; 8'hED: r=8'h53; 8'hEE: r=8'h99; 8'hEF: r=8'h61;
            8'hF0: r=8'h17; 8'hF1: r=8'h2B; 8'hF2: r=8'h04; 8'hF3: r=8'h7E;
            8'hF4: r=8'hBA; 8'hF5: r=8'h77; 8'hF6: r=8'hD6; 8'hF7: r=8'h26;
            8'hF8: r=8'hE1; 8'hF9: r=8'h69; 8'hFA: r=8'h14; 8'hFB: r=8'h63;
            8'hFC: r=8'h55; 8'hFD: r=8'h21; 8'hFE: r=8'h0C; 8'hFF: r=8'h7D;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? REDUCE_POLY : 8'h00);
    endfunction

    // inverse mix of one column, byte 0 in the top bits
    function automatic word_t inv_mix_col(input word_t w);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        word_t      r;
        for (int i = 0; i < 4; i++) begin
            a[i]  = w[31-8*i -: 8];
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        r[31:24] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
        r[23:16] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
        r[15:8]  = md[0] ^ m9[1] ^ me[2] ^ mb[3];
        r[7:0]   = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        return r;
    endfunction

    // inverse shift rows then inverse S-box, byte 0 in bits 127:120
    function automatic block_t unshift_unsub(input block_t s);
        block_t r;
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                r[127-8*(c*4+w) -: 8] = inv_sbox(s[127-8*((((c-w+4)%4)*4)+w) -: 8]);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/aesd_key_sched.sv =====
// Key expansion: one schedule word per cycle into a per-round key store.
module aesd_key_sched (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [127:0]          key,
    output logic [127:0]          rd_keys [aesd_pkg::ROUNDS+1],
    output aesd_pkg::ks_status_t  status
);

    logic                                   busy_reg, busy_next;
    logic                                   ready_reg, ready_next;
    logic [aesd_pkg::WORD_IDX_W-1:0]        idx_reg, idx_next;
    logic [7:0]                             rc_reg, rc_next;
    aesd_pkg::word_t                        win_reg [4];
    aesd_pkg::word_t                        win_next [4];
    logic [127:0]                           rk_reg [aesd_pkg::ROUNDS+1];
    aesd_pkg::word_t                        t;
    aesd_pkg::word_t                        nw;
    logic [aesd_pkg::ROUND_IDX_W-1:0]       wr_round;

    // new word from the last four
    always_comb begin
        t = win_reg[3];
        if (idx_reg[1:0] == 2'd0) begin
            t = {t[23:0], t[31:24]};
            t = {aesd_pkg::fwd_sbox(t[31:24]), aesd_pkg::fwd_sbox(t[23:16]),
                 aesd_pkg::fwd_sbox(t[15:8]), aesd_pkg::fwd_sbox(t[7:0])};
            t = t ^ {rc_reg, 24'h0};
        end
        nw = win_reg[0] ^ t;
        wr_round = idx_reg[5:2];
    end

    always_comb begin
        busy_next  = busy_reg;
        ready_next = ready_reg;
        idx_next   = idx_reg;
        rc_next    = rc_reg;
        for (int i = 0; i < 4; i++) win_next[i] = win_reg[i];
        if (start) begin
            busy_next  = 1'b1;
            ready_next = 1'b0;
            idx_next   = aesd_pkg::WORD_IDX_W'(aesd_pkg::KEY_WORDS);
            rc_next    = 8'h01;
            win_next[0] = key[127:96];
            win_next[1] = key[95:64];
            win_next[2] = key[63:32];
            win_next[3] = key[31:0];
        end else if (busy_reg) begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = nw;
            if (idx_reg[1:0] == 2'd0) rc_next = aesd_pkg::xtime(rc_reg);
            idx_next = idx_reg + 1'b1;
            if (idx_reg == aesd_pkg::WORD_IDX_W'(aesd_pkg::TOTAL_WORDS - 1)) begin
                busy_next  = 1'b0;
                ready_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            ready_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            ready_reg <= ready_next;
        end
        idx_reg <= idx_next;
        rc_reg  <= rc_next;
        for (int i = 0; i < 4; i++) win_reg[i] <= win_next[i];
        if (start) begin
            rk_reg[0] <= key;
        end else if (busy_reg) begin
            rk_reg[wr_round][127-32*idx_reg[1:0] -: 32] <= nw;
        end
    end

    // every round key is read at a fixed place by its own stage
    assign rd_keys = rk_reg;
    assign status  = '{busy: busy_reg, ready: ready_reg};

endmodule

// ===== rtl/aesd_round.sv =====
// One inverse-round pipeline stage: unshift/unsub, add round key, optional unmix.
module aesd_round #(
    parameter int ROUND = 9
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic [127:0] in_state,
    input  logic [127:0] stage_key,
    output logic         out_valid,
    output logic [127:0] out_state
);

    logic         valid_reg;
    logic [127:0] state_reg, state_next;
    logic [127:0] ak;

    always_comb begin
        ak = aesd_pkg::unshift_unsub(in_state) ^ stage_key;
        state_next = ak;
        if (ROUND != 0) begin
            for (int c = 0; c < 4; c++) begin
                state_next[127-32*c -: 32] = aesd_pkg::inv_mix_col(ak[127-32*c -: 32]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

// ===== rtl/aes128_block_decrypt_unit.sv =====
// Top level: AES-128 block decryption, eleven-stage pipeline with key schedule.
// AES-128 decrypt unit.
// Ciphertext blocks arrive on the s_ stream channel, plaintext leaves on m_.
// s_tdata = {cipher_low, cipher_high}, m_tdata = {plain_low, plain_high};
// within each half byte 0 (or 8) is the most significant.
// The key is loaded through the write port: index 0 key_high, index 1 key_low.
// Any key write (and reset) marks the schedule stale; the first transaction
// after that waits while the schedule is expanded, one word per cycle,
// so s_tready stays low until the expansion is done.
// Datapath: an initial key-addition stage followed by ten round stages, one
// inverse round per stage; a new block may enter every cycle once the
// schedule is ready, unless the receiver stalls.
// The key schedule holds the input only after a key change or reset.
// When the receiver stalls (m_tready low with m_tvalid high) the whole
// pipeline holds; nothing is lost or repeated, and the input stalls too.
// Reset (aresetn low, synchronous) empties the pipeline and the schedule.
module aes128_block_decrypt_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] cipher_high, [127:64] cipher_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] plain_high, [127:64] plain_low
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);

    localparam int NSTG = aesd_pkg::ROUNDS + 1;

    logic [63:0]          key_high_reg, key_low_reg;
    logic                 stale_reg;
    aesd_pkg::ks_status_t ks_st;
    logic                 ks_start;
    logic [127:0]         rk [NSTG];
    logic                 en;
    logic                 v [NSTG];
    logic [127:0]         st [NSTG];
    logic                 v0_reg;
    logic [127:0]         st0_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            stale_reg    <= 1'b1;
        end else begin
            if (ks_start) stale_reg <= 1'b0;
            if (cfg_we) begin
                unique case (cfg_index)
                    aesd_pkg::CFG_KEY_HIGH: begin
                        key_high_reg <= cfg_wdata;
                        stale_reg    <= 1'b1;
                    end
                    aesd_pkg::CFG_KEY_LOW: begin
                        key_low_reg <= cfg_wdata;
                        stale_reg   <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // expand on demand, when a block is waiting
    assign ks_start = stale_reg && s_tvalid && !ks_st.busy;

    assign en = !m_tvalid || m_tready;
    assign s_tready = en && ks_st.ready && !stale_reg;

    // round-key reads are fixed per stage; key store is flops
    aesd_key_sched u_ks (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ks_start),
        .key      ({key_high_reg, key_low_reg}),
        .rd_keys  (rk),
        .status   (ks_st)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid && s_tready;
        end
        if (en) st0_reg <= {s_tdata[63:0], s_tdata[127:64]} ^ rk[aesd_pkg::ROUNDS];
    end

    assign v[0]  = v0_reg;
    assign st[0] = st0_reg;

    genvar g;
    generate
        for (g = 0; g < aesd_pkg::ROUNDS; g++) begin : g_rnd
            aesd_round #(.ROUND(aesd_pkg::ROUNDS - 1 - g)) u_rnd (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (v[g]),
                .in_state  (st[g]),
                .stage_key (rk[aesd_pkg::ROUNDS - 1 - g]),
                .out_valid (v[g+1]),
                .out_state (st[g+1])
            );
        end
    endgenerate

    assign m_tvalid = v[aesd_pkg::ROUNDS];
    assign m_tdata  = {st[aesd_pkg::ROUNDS][63:0], st[aesd_pkg::ROUNDS][127:64]};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (ks_st.ready && !ks_st.busy))
        else $error("block accepted before key schedule ready");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ks_st.busy |-> !s_tready)
        else $error("input open during key expansion");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("stalled result changed");

endmodule

// ===== tb/sv/tb_aes128_block_decrypt_unit.sv =====
// Testbench for the AES-128 block decryption unit: self-predicting, stream stimulus.
`timescale 1ns / 1ps

module tb_aes128_block_decrypt_unit;

    // pipeline is eleven stages; the schedule is expanded again after a key change
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam int NUM_RANDOM   = 636;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } half_pair_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // [63:0] cipher_high, [127:64] cipher_low
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;    // [63:0] plain_high, [127:64] plain_low
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_wdata;

    // predictor state
    logic [63:0] key_hi_q, key_lo_q;
    logic [31:0] sched_words [aesd_pkg::TOTAL_WORDS];
    logic        sched_valid;

    half_pair_t plain_queue [$];
    int         errors;
    int         send_idle_pct, recv_idle_pct;
    int         stall_count;

    aes128_block_decrypt_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // --- predictor -------------------------------------------------------
    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_times(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) acc ^= x;
            x = gf_double(x);
        end
        return acc;
    endfunction

    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        sched_words[0] = key_hi_q[63:32];
        sched_words[1] = key_hi_q[31:0];
        sched_words[2] = key_lo_q[63:32];
        sched_words[3] = key_lo_q[31:0];
        for (int i = aesd_pkg::KEY_WORDS; i < aesd_pkg::TOTAL_WORDS; i++) begin
            t = sched_words[i-1];
            if (i % aesd_pkg::KEY_WORDS == 0) begin
                t = {t[23:0], t[31:24]};
                t = {aesd_pkg::fwd_sbox(t[31:24]), aesd_pkg::fwd_sbox(t[23:16]),
                     aesd_pkg::fwd_sbox(t[15:8]), aesd_pkg::fwd_sbox(t[7:0])};
                t ^= {rcon, 24'h0};
                rcon = gf_double(rcon);
            end
            sched_words[i] = sched_words[i-aesd_pkg::KEY_WORDS] ^ t;
        end
        sched_valid = 1'b1;
    endfunction

    // state[n] is block byte n; column c holds bytes 4c..4c+3
    function automatic half_pair_t decrypt_block(input logic [63:0] c_hi,
                                                 input logic [63:0] c_lo);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] a0, a1, a2, a3;
        half_pair_t res;
        if (!sched_valid) build_schedule();
        for (int n = 0; n < 8; n++) begin
            st[n]   = c_hi[63-8*n -: 8];
            st[n+8] = c_lo[63-8*n -: 8];
        end
        for (int rnd = aesd_pkg::ROUNDS; rnd >= 0; rnd--) begin
            if (rnd != aesd_pkg::ROUNDS) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[c*4+r] = aesd_pkg::inv_sbox(st[((c-r+4)%4)*4+r]);
                st = tmp;
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[c*4+r] ^= sched_words[rnd*4+c][31-8*r -: 8];
            if (rnd != aesd_pkg::ROUNDS && rnd != 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
                    st[c*4]   = gf_times(a0,8'h0e)^gf_times(a1,8'h0b)
                              ^ gf_times(a2,8'h0d)^gf_times(a3,8'h09);
                    st[c*4+1] = gf_times(a0,8'h09)^gf_times(a1,8'h0e)
                              ^ gf_times(a2,8'h0b)^gf_times(a3,8'h0d);
                    st[c*4+2] = gf_times(a0,8'h0d)^gf_times(a1,8'h09)
                              ^ gf_times(a2,8'h0e)^gf_times(a3,8'h0b);
                    st[c*4+3] = gf_times(a0,8'h0b)^gf_times(a1,8'h0d)
                              ^ gf_times(a2,8'h09)^gf_times(a3,8'h0e);
                end
            end
        end
        for (int n = 0; n < 8; n++) begin
            res.hi[63-8*n -: 8] = st[n];
            res.lo[63-8*n -: 8] = st[n+8];
        end
        return res;
    endfunction

    // --- drivers ---------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        $display("MISMATCH %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    // one transaction on the cipher channel; the prediction is queued on acceptance
    task automatic send_block(input logic [63:0] c_hi, input logic [63:0] c_lo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c_lo, c_hi};
        do @(posedge aclk); while (!s_tready);
        plain_queue.push_back(decrypt_block(c_hi, c_lo));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (plain_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // key write only while idle; index beyond the two keys must be ignored
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == aesd_pkg::CFG_KEY_HIGH) begin
            key_hi_q = val; sched_valid = 1'b0;
        end else if (idx == aesd_pkg::CFG_KEY_LOW) begin
            key_lo_q = val; sched_valid = 1'b0;
        end
        @(posedge aclk);
    endtask

    task automatic load_key(input logic [63:0] k_hi, input logic [63:0] k_lo);
        wait_idle();
        write_reg(aesd_pkg::CFG_KEY_HIGH, k_hi);
        write_reg(aesd_pkg::CFG_KEY_LOW, k_lo);
    endtask

    // --- result checker and watchdog ------------------------------------
    always @(posedge aclk) begin
        half_pair_t exp;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (plain_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", m_tdata[63:0], '0);
                end else begin
                    exp = plain_queue.pop_front();
                    if (m_tdata[63:0] !== exp.hi)
                        report_mismatch("plain_high", m_tdata[63:0], exp.hi);
                    if (m_tdata[127:64] !== exp.lo)
                        report_mismatch("plain_low", m_tdata[127:64], exp.lo);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count > STALL_LIMIT) begin
                $display("aes128_block_decrypt_unit test failed");
                $finish;
            end
        end
    end

    // --- tests -----------------------------------------------------------
    // first block after reset uses the all-zero reset key
    task automatic test_reset_key();
        send_block(64'h0, 64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // FIPS-197 appendix vector plus extreme keys and data
    task automatic test_directed();
        load_key(64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F);
        send_block(64'h69C4_E0D8_6A7B_0430, 64'hD8CD_B780_70B4_C55A);
        send_block(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        load_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h0, 64'h0);
        send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        // only the high half changes: schedule must still be rebuilt
        wait_idle();
        write_reg(aesd_pkg::CFG_KEY_HIGH, 64'h0);
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        // an unknown register index leaves the schedule alone
        wait_idle();
        write_reg(2'd2, 64'hDEAD_BEEF_0000_0000);
        write_reg(2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        wait_idle();
        write_reg(aesd_pkg::CFG_KEY_LOW, 64'h0);
        send_block(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(39) == 0)
                load_key({$urandom, $urandom}, {$urandom, $urandom});
            send_block({$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    initial begin
        errors        = 0;
        stall_count   = 0;
        send_idle_pct = 14;
        recv_idle_pct = 63;
        key_hi_q      = '0;
        key_lo_q      = '0;
        sched_valid   = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_key();
        test_directed();
        test_random(NUM_RANDOM / 3);
        send_idle_pct = 63;
        recv_idle_pct = 14;
        test_random(NUM_RANDOM / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(NUM_RANDOM / 3);

        wait_idle();
        if (errors == 0)
            $display("aes128_block_decrypt_unit test passed");
        else
            $display("aes128_block_decrypt_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/aesd_pkg.sv
rtl/aesd_key_sched.sv
rtl/aesd_round.sv
rtl/aes128_block_decrypt_unit.sv
tb/sv/tb_aes128_block_decrypt_unit.sv
